// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the array list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PAL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pal_pkg.sv -----
// Package with the types, codes and command/status structs of the array list engine.
package pal_pkg;

  // Default list capacity.
  localparam int unsigned PAL_CAPACITY = 64;

  // Fixed field widths of the channels.
  localparam int unsigned ACT_W  = 4;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned FPOS_W = 6;
  localparam int unsigned MCNT_W = 7;
  localparam int unsigned SIZE_W = 7;

  // Action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_INS_HEAD = 4'd0,
    ACT_INS_TAIL = 4'd1,
    ACT_INS_POS  = 4'd2,
    ACT_RM_HEAD  = 4'd3,
    ACT_RM_TAIL  = 4'd4,
    ACT_RM_POS   = 4'd5,
    ACT_RM_KEY   = 4'd6,
    ACT_FIND_KEY = 4'd7,
    ACT_READ_POS = 4'd8,
    ACT_COUNT    = 4'd9,
    ACT_CLEAR    = 4'd10
  } pal_action_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_NOKEY  = 3'd4
  } pal_status_t;

  // Action classes as seen by the controller.
  typedef enum logic [2:0] {
    K_INS,
    K_RMPOS,
    K_READ,
    K_RMKEY,
    K_FIND,
    K_COUNT,
    K_OTHER
  } pal_kind_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CAPT,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_DRAIN,
    S_PUT,
    S_FINISH
  } pal_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;       // ready for a new input beat
    logic dec_load;   // load decode outcome, target position and pointer
    logic rd_p;       // read the entry at the target position
    logic capt;       // capture read data as the found entry, pointer to target + 1
    logic scan_step;  // read the entry under the pointer and advance
    logic hit_load;   // take the matching entry as the target
    logic nokey_set;  // report key not found
    logic mcnt_inc;   // count one key match
    logic shift_up;   // move one entry up by one place
    logic shift_dn;   // move one entry down by one place
    logic put_en;     // write the new entry at the target position
    logic finish;     // load the result register and commit the size
  } pal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic      in_fire;
    pal_kind_t kind;
    logic      dec_err;
    logic      p_lt_cnt;
    logic      pn_lt_cnt;
    logic      up_last;
    logic      dn_last;
    logic      hit;
    logic      scan_last;
    logic      out_free;
  } pal_sts_t;

endpackage

// ----- hw/rtl/pal_if.sv -----
// Valid/ready channel interfaces for the input actions and the results.

// Input channel: one action per beat.
interface pal_in_if import pal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [KEY_W-1:0] entry_key;
  logic [VAL_W-1:0]        entry_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, action, entry_key, entry_value, position, input ready);
  modport sink   (input valid, action, entry_key, entry_value, position, output ready);
endinterface

// Result channel: one result per beat.
interface pal_out_if import pal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [KEY_W-1:0] found_key;
  logic [VAL_W-1:0]        found_value;
  logic [FPOS_W-1:0]       found_position;
  logic [MCNT_W-1:0]       match_count;
  logic [SIZE_W-1:0]       list_size;

  modport source (output valid, status, found_key, found_value, found_position,
                  match_count, list_size, input ready);
  modport sink   (input valid, status, found_key, found_value, found_position,
                  match_count, list_size, output ready);
endinterface

// ----- hw/rtl/pal_ctrl.sv -----
// Controller state machine that sequences decode, scans, shifts and result hand-off.
module pal_ctrl import pal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  pal_sts_t sts,
  output pal_cmd_t cmd
);

  pal_state_t state_r;
  pal_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.dec_load = 1'b1;
        if (sts.dec_err) begin
          state_nxt = S_FINISH;
        end else begin
          case (sts.kind)
            K_INS:   state_nxt = sts.p_lt_cnt ? S_SHUP : S_PUT;
            K_RMPOS: state_nxt = S_READ;
            K_READ:  state_nxt = S_READ;
            K_RMKEY: state_nxt = S_SCAN;
            K_FIND:  state_nxt = S_SCAN;
            K_COUNT: state_nxt = S_SCAN;
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_READ: begin
        cmd.rd_p  = 1'b1;
        state_nxt = S_CAPT;
      end
      S_CAPT: begin
        cmd.capt = 1'b1;
        if (sts.kind == K_RMPOS && sts.pn_lt_cnt) begin
          state_nxt = S_SHDN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.kind == K_COUNT) begin
          cmd.mcnt_inc = sts.hit;
          if (sts.scan_last) begin
            state_nxt = S_FINISH;
          end
        end else if (sts.hit) begin
          // First match ends the search; a remove then closes the gap.
          cmd.hit_load = 1'b1;
          if (sts.kind == K_RMKEY && !sts.scan_last) begin
            state_nxt = S_SHDN;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (sts.scan_last) begin
          cmd.nokey_set = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_SHUP: begin
        cmd.shift_up = 1'b1;
        if (sts.up_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_SHDN: begin
        cmd.shift_dn = 1'b1;
        if (sts.dn_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last moved entry is written back in this cycle.
        state_nxt = (sts.kind == K_INS) ? S_PUT : S_FINISH;
      end
      S_PUT: begin
        cmd.put_en = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pal_dp.sv -----
// Datapath: entry memory, size counter, pointers, search compare and result register.
module pal_dp import pal_pkg::*; #(
  parameter int unsigned CAPACITY = PAL_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  pal_in_if.sink   in_ch,
  pal_out_if.source out_ch,
  input  pal_cmd_t cmd,
  output pal_sts_t sts
);

  `include "assert_macros.svh"

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned DW = KEY_W + VAL_W;

  // Captured action.
  logic [ACT_W-1:0] act_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;

  // List state and walk registers.
  logic [CW-1:0]    cnt_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    ptr_r;
  logic [PW-1:0]    ptr_nxt;
  logic [DW-1:0]    mem [CAPACITY];
  logic [DW-1:0]    rd_data_r;
  logic [PW-1:0]    rd_tag_r;
  logic             rd_vld_r;
  logic             wb_vld_r;
  logic [PW-1:0]    wb_addr_r;
  logic [ST_W-1:0]  st_r;
  logic [DW-1:0]    f_r;
  logic [CW-1:0]    mcnt_r;

  // Result register.
  logic                    out_valid_r;
  logic [ST_W-1:0]         out_status_r;
  logic [KEY_W-1:0]        out_key_r;
  logic [VAL_W-1:0]        out_val_r;
  logic [FPOS_W-1:0]       out_fpos_r;
  logic [MCNT_W-1:0]       out_mcnt_r;
  logic [SIZE_W-1:0]       out_size_r;

  // Combinational decode and walk signals.
  logic [PW-1:0]    cnt_ext;
  logic [PW-1:0]    p_calc;
  pal_kind_t        kind;
  logic [ST_W-1:0]  dec_code;
  logic             full;
  logic             empty;
  logic             rd_en;
  logic             scan_rd;
  logic [PW-1:0]    rd_addr;
  logic             st_ok;
  logic [CW-1:0]    cnt_nxt;

  assign cnt_ext = PW'(cnt_r);
  assign full    = (cnt_r == CW'(CAPACITY));
  assign empty   = (cnt_r == '0);

  // Action class and target position.
  always_comb begin
    kind   = K_OTHER;
    p_calc = PW'(pos_r);
    case (act_r)
      ACT_INS_HEAD: begin kind = K_INS;   p_calc = '0; end
      ACT_INS_TAIL: begin kind = K_INS;   p_calc = cnt_ext; end
      ACT_INS_POS:  begin kind = K_INS; end
      ACT_RM_HEAD:  begin kind = K_RMPOS; p_calc = '0; end
      ACT_RM_TAIL:  begin kind = K_RMPOS; p_calc = PW'(cnt_ext - PW'(1)); end
      ACT_RM_POS:   begin kind = K_RMPOS; end
      ACT_RM_KEY:   begin kind = K_RMKEY; end
      ACT_FIND_KEY: begin kind = K_FIND; end
      ACT_READ_POS: begin kind = K_READ; end
      ACT_COUNT:    begin kind = K_COUNT; end
      default:      begin kind = K_OTHER; end
    endcase
  end

  // Error checks at decode; a full list reports before a bad position.
  always_comb begin
    dec_code = ST_OK;
    case (kind)
      K_INS: begin
        if (full) begin
          dec_code = ST_FULL;
        end else if (p_calc > cnt_ext) begin
          dec_code = ST_BADPOS;
        end
      end
      K_RMPOS, K_READ: begin
        if (empty) begin
          dec_code = ST_EMPTY;
        end else if ((act_r == ACT_RM_POS || act_r == ACT_READ_POS) &&
                     (p_calc >= cnt_ext)) begin
          dec_code = ST_BADPOS;
        end
      end
      K_RMKEY, K_FIND, K_COUNT: begin
        if (empty) begin
          dec_code = ST_EMPTY;
        end
      end
      default: begin
        dec_code = ST_OK;
      end
    endcase
  end

  // Status toward the controller.
  assign sts.in_fire   = in_ch.valid && in_ch.ready;
  assign sts.kind      = kind;
  assign sts.dec_err   = (dec_code != ST_OK);
  assign sts.p_lt_cnt  = (p_calc < cnt_ext);
  assign sts.pn_lt_cnt = (PW'(p_r + PW'(1)) < cnt_ext);
  assign sts.up_last   = (PW'(ptr_r - PW'(1)) == p_r);
  assign sts.dn_last   = (PW'(ptr_r + PW'(1)) == cnt_ext);
  assign sts.hit       = rd_vld_r && (rd_data_r[DW-1:VAL_W] == key_r);
  assign sts.scan_last = rd_vld_r && (PW'(rd_tag_r + PW'(1)) == cnt_ext);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready = cmd.idle;

  // Input capture.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act_r <= in_ch.action;
      key_r <= in_ch.entry_key;
      val_r <= in_ch.entry_value;
      pos_r <= in_ch.position;
    end
  end

  // Read port address selection.
  assign scan_rd = cmd.scan_step && (ptr_r < cnt_ext);
  assign rd_en   = cmd.rd_p || cmd.shift_up || cmd.shift_dn || scan_rd;
  always_comb begin
    if (cmd.rd_p) begin
      rd_addr = p_r;
    end else if (cmd.shift_up) begin
      rd_addr = PW'(ptr_r - PW'(1));
    end else begin
      rd_addr = ptr_r;
    end
  end

  // Entry memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wb_vld_r) begin
      mem[wb_addr_r[AW-1:0]] <= rd_data_r;
    end else if (cmd.put_en) begin
      mem[p_r[AW-1:0]] <= {key_r, val_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
    rd_tag_r <= rd_addr;
  end

  // Walk pointer: the matching entry's successor wins over a scan advance.
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.dec_load) begin
      ptr_nxt = (kind == K_INS) ? cnt_ext : '0;
    end else if (cmd.capt) begin
      ptr_nxt = PW'(p_r + PW'(1));
    end else if (cmd.hit_load) begin
      ptr_nxt = PW'(rd_tag_r + PW'(1));
    end else if (scan_rd || cmd.shift_dn) begin
      ptr_nxt = PW'(ptr_r + PW'(1));
    end else if (cmd.shift_up) begin
      ptr_nxt = PW'(ptr_r - PW'(1));
    end
  end

  // Walk and working result registers.
  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    wb_addr_r <= cmd.shift_up ? ptr_r : PW'(ptr_r - PW'(1));
    if (cmd.dec_load) begin
      st_r   <= dec_code;
      p_r    <= p_calc;
      f_r    <= '0;
      mcnt_r <= '0;
    end else begin
      if (cmd.capt) begin
        f_r <= rd_data_r;
      end
      if (cmd.hit_load) begin
        p_r <= rd_tag_r;
        f_r <= rd_data_r;
      end
      if (cmd.nokey_set) begin
        st_r <= ST_NOKEY;
      end
      if (cmd.mcnt_inc) begin
        mcnt_r <= CW'(mcnt_r + CW'(1));
      end
    end
  end

  // Control flags with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      wb_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_rd;
      wb_vld_r <= cmd.shift_up || cmd.shift_dn;
    end
  end

  // Size after the action.
  assign st_ok = (st_r == ST_OK);
  always_comb begin
    cnt_nxt = cnt_r;
    if (act_r == ACT_CLEAR) begin
      cnt_nxt = '0;
    end else if (st_ok && (kind == K_INS)) begin
      cnt_nxt = CW'(cnt_r + CW'(1));
    end else if (st_ok && (kind == K_RMPOS || kind == K_RMKEY)) begin
      cnt_nxt = CW'(cnt_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded when the result register is free.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= st_r;
      out_key_r    <= f_r[DW-1:VAL_W];
      out_val_r    <= f_r[VAL_W-1:0];
      out_fpos_r   <= (st_ok && (act_r <= ACT_READ_POS)) ? FPOS_W'(p_r) : '0;
      out_mcnt_r   <= MCNT_W'(mcnt_r);
      out_size_r   <= SIZE_W'(cnt_nxt);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_key      = out_key_r;
  assign out_ch.found_value    = out_val_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.match_count    = out_mcnt_r;
  assign out_ch.list_size      = out_size_r;

  // The size never passes the capacity.
  `PAL_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_r <= CW'(CAPACITY), "entry count above capacity")
  // A shift writeback and a new-entry write never share the write port.
  `PAL_ASSERT_IMPLY(a_wr_port, wb_vld_r, !cmd.put_en, "write port conflict")
  // Shifts only ever write inside the list or at its end.
  `PAL_ASSERT_IMPLY(a_wb_range, wb_vld_r, wb_addr_r <= cnt_ext, "shift write beyond list end")

endmodule

// ----- hw/rtl/positional_array_list_engine_unit.sv -----
// Top level of the positional array list engine: controller plus datapath.
//
//   channel  | direction | handshake     | payload
//   in_ch    | in        | valid / ready | action, entry_key, entry_value, position
//   out_ch   | out       | valid / ready | status, found_key, found_value,
//            |           |               | found_position, match_count, list_size
//
// One action at a time. An insert or remove that shifts moves the entries between the target
// and the list end one place, an append writes directly, a read or a tail remove reads the
// target, a remove by key, find and count scan from the head, and rejected actions and clear
// go straight to the result; the next beat is taken in the idle state after the result loads.
// Reset (rst_n low, synchronous) empties the list; entry contents stay unset.
// A waiting result does not block the input; a stalled output holds the next action in
// its last cycle until the result register frees.
module positional_array_list_engine_unit import pal_pkg::*; #(
  parameter int unsigned CAPACITY = PAL_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);

  pal_cmd_t cmd;
  pal_sts_t sts;

  // Sequencer.
  pal_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Storage, compare and result register.
  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
